// ----- rtl/clle_pkg.sv -----
// Shared definitions for the cursor linked-list engine: field widths, command
// and status codes, and the command/status bundles between controller and datapath.
// No dependencies.
package clle_pkg;

  // Default sizing of the node store.
  localparam int NODE_COUNT_DEF  = 256;
  localparam int VALUE_WIDTH_DEF = 32;

  // Widths of the fields carried on the stream ports.
  localparam int CMD_W  = 3;
  localparam int ELEM_W = 32;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;

  // Input beat layout, first field in the lowest bits.
  localparam int IN_ELEM_LO = CMD_W;
  localparam int IN_HEAD_LO = IN_ELEM_LO + ELEM_W;
  localparam int IN_POS_LO  = IN_HEAD_LO + IDX_W;
  localparam int IN_BITS    = IN_POS_LO + IDX_W;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output beat layout.
  localparam int OUT_BITS  = IDX_W + IDX_W + ELEM_W + STAT_W;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_INIT        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MAKE_EMPTY  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIND        = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FIND_PREV   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DELETE_LIST = 3'd6;
  localparam logic [CMD_W-1:0] CMD_READ_NODE   = 3'd7;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd2;

  // Datapath operations issued by the controller.
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE       = 4'd0;
  localparam dp_op_t OP_LOAD       = 4'd1;
  localparam dp_op_t OP_SWEEP      = 4'd2;
  localparam dp_op_t OP_RD_HEAD    = 4'd3;
  localparam dp_op_t OP_RD_POS     = 4'd4;
  localparam dp_op_t OP_ADVANCE    = 4'd5;
  localparam dp_op_t OP_UNLINK     = 4'd6;
  localparam dp_op_t OP_GIVE_CUR   = 4'd7;
  localparam dp_op_t OP_CLEAR_HEAD = 4'd8;
  localparam dp_op_t OP_GIVE_ADV   = 4'd9;
  localparam dp_op_t OP_TAKE_RD    = 4'd10;
  localparam dp_op_t OP_TAKE_EMPTY = 4'd11;
  localparam dp_op_t OP_TAKE_INS   = 4'd12;
  localparam dp_op_t OP_INS_LINK   = 4'd13;
  localparam dp_op_t OP_INS_HOOK   = 4'd14;
  localparam dp_op_t OP_EMIT       = 4'd15;

  // Source of the result fields when a beat is emitted.
  typedef logic [2:0] res_sel_t;
  localparam res_sel_t RES_NONE = 3'd0;
  localparam res_sel_t RES_T    = 3'd1;
  localparam res_sel_t RES_CUR  = 3'd2;
  localparam res_sel_t RES_PREV = 3'd3;
  localparam res_sel_t RES_READ = 3'd4;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t              op;
    res_sel_t            res_sel;
    logic [STAT_W-1:0]   status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic head_zero;
    logic free_empty;
    logic match;
    logic link_zero;
    logic cur_zero;
    logic count_full;
    logic sweep_last;
  } dp_stat_t;

endpackage

// ----- rtl/cursor_linked_list_engine.sv -----
// Top level of the cursor linked-list engine: stream ports, controller and datapath.
// Depends on clle_pkg, clle_ctrl and clle_dp.
//
//   channel   direction  group    beat contents
//   command   in         s_axis   command, element, list_head, position
//   result    out        m_axis   result_position, next_index, element_out, status
//
// One command is worked at a time; a new beat is taken while the previous
// result still waits in the output register. After reset a rebuild pass writes
// the link store, and no beat is taken meanwhile. Find, find_previous and delete
// walk the list one node per step, delete_list and make_empty free one node per
// step, and init rebuilds the whole link store. The per-node step is set by the
// registered read of the link store.
module cursor_linked_list_engine
  import clle_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // command[2:0], element[34:3], list_head[42:35], position[50:43], zero fill
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // result_position[7:0], next_index[15:8], element_out[47:16], status[49:48], zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  dp_cmd_t           dp_cmd;
  dp_stat_t          dp_stat;
  logic [IDX_W-1:0]  result_position;
  logic [IDX_W-1:0]  next_index;
  logic [ELEM_W-1:0] element_out;
  logic [STAT_W-1:0] status;

  // Sequencer.
  clle_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tdata[CMD_W-1:0]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .dp_cmd     (dp_cmd),
    .dp_stat    (dp_stat)
  );

  // Stores and walk registers.
  clle_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .element         (s_axis_tdata[IN_ELEM_LO +: ELEM_W]),
    .list_head       (s_axis_tdata[IN_HEAD_LO +: IDX_W]),
    .position        (s_axis_tdata[IN_POS_LO +: IDX_W]),
    .result_position (result_position),
    .next_index      (next_index),
    .element_out     (element_out),
    .status          (status)
  );

  // Pack the result beat.
  assign m_axis_tdata = M_TDATA_W'({status, element_out, next_index, result_position});

endmodule

// ----- rtl/clle_dp.sv -----
// Datapath of the linked-list engine: link and value stores, walk registers,
// free-list top register and the result register.
// Depends on clle_pkg.
module clle_dp
  import clle_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [ELEM_W-1:0] element,
  input  logic [IDX_W-1:0]  list_head,
  input  logic [IDX_W-1:0]  position,
  output logic [IDX_W-1:0]  result_position,
  output logic [IDX_W-1:0]  next_index,
  output logic [ELEM_W-1:0] element_out,
  output logic [STAT_W-1:0] status
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NODE_COUNT + 1);

  typedef logic [IW-1:0]          node_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  // Reduce an index field modulo the node count by restoring subtraction.
  function automatic node_t to_node(input logic [IDX_W-1:0] b);
    logic [31:0] v;
    v = 32'(b);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (v >= (32'(NODE_COUNT) << k)) begin
        v = v - (32'(NODE_COUNT) << k);
      end
    end
    return v[IW-1:0];
  endfunction

  // Fit a node index into an output field.
  function automatic logic [IDX_W-1:0] to_field(input node_t n);
    logic [IW+IDX_W-1:0] w;
    w = {{IDX_W{1'b0}}, n};
    return w[IDX_W-1:0];
  endfunction

  // Fit a stored value into the element field.
  function automatic logic [ELEM_W-1:0] to_elem(input value_t v);
    logic [VALUE_WIDTH+ELEM_W-1:0] w;
    w = {{ELEM_W{1'b0}}, v};
    return w[ELEM_W-1:0];
  endfunction

  // Stores. Entry 0 of the link store lives in free_top.
  node_t  link_mem  [NODE_COUNT];
  value_t value_mem [NODE_COUNT];

  node_t         lk_rdata;
  value_t        vl_rdata;
  logic          rd_zero;
  node_t         free_top;

  value_t        x;
  value_t        x_in;
  node_t         head;
  node_t         pos;
  node_t         cur;
  node_t         prev;
  node_t         t;
  node_t         idx;
  logic [CW-1:0] count;
  logic          first;

  logic          lk_re;
  node_t         lk_raddr;
  logic          lk_we;
  logic          lk_we_mem;
  node_t         lk_waddr;
  node_t         lk_wdata;
  logic          vl_we;
  logic          ft_set;
  node_t         ft_val;
  node_t         rd_link;
  logic          sweep_last;
  logic [VALUE_WIDTH+ELEM_W-1:0] x_wide;

  assign x_wide     = {{VALUE_WIDTH{1'b0}}, element};
  assign x_in       = x_wide[VALUE_WIDTH-1:0];
  assign rd_link    = rd_zero ? free_top : lk_rdata;
  assign sweep_last = (idx == IW'(NODE_COUNT - 1));
  assign lk_we_mem  = lk_we && (lk_waddr != '0);

  // Port control for each operation.
  always_comb begin
    lk_re    = 1'b0;
    lk_raddr = '0;
    lk_we    = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    vl_we    = 1'b0;
    ft_set   = 1'b0;
    ft_val   = '0;
    unique case (cmd.op) inside
      OP_SWEEP: begin
        lk_we    = 1'b1;
        lk_waddr = idx;
        lk_wdata = sweep_last ? '0 : idx + node_t'(1);
      end
      OP_RD_HEAD: begin
        lk_re    = 1'b1;
        lk_raddr = head;
      end
      OP_RD_POS: begin
        lk_re    = 1'b1;
        lk_raddr = pos;
      end
      OP_ADVANCE: begin
        lk_re    = 1'b1;
        lk_raddr = rd_link;
      end
      OP_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = prev;
        lk_wdata = rd_link;
      end
      OP_GIVE_CUR: begin
        lk_we    = 1'b1;
        lk_waddr = cur;
        lk_wdata = free_top;
        ft_set   = 1'b1;
        ft_val   = cur;
      end
      OP_CLEAR_HEAD: begin
        lk_we    = 1'b1;
        lk_waddr = head;
        lk_wdata = '0;
        lk_re    = 1'b1;
        lk_raddr = rd_link;
      end
      OP_GIVE_ADV: begin
        lk_we    = 1'b1;
        lk_waddr = cur;
        lk_wdata = free_top;
        ft_set   = 1'b1;
        ft_val   = cur;
        lk_re    = 1'b1;
        lk_raddr = rd_link;
      end
      OP_TAKE_RD: begin
        lk_re    = 1'b1;
        lk_raddr = free_top;
      end
      OP_TAKE_EMPTY: begin
        ft_set   = 1'b1;
        ft_val   = rd_link;
        lk_we    = 1'b1;
        lk_waddr = t;
        lk_wdata = '0;
      end
      OP_TAKE_INS: begin
        ft_set   = 1'b1;
        ft_val   = rd_link;
        vl_we    = 1'b1;
        lk_re    = 1'b1;
        lk_raddr = pos;
      end
      OP_INS_LINK: begin
        lk_we    = 1'b1;
        lk_waddr = t;
        lk_wdata = rd_link;
      end
      OP_INS_HOOK: begin
        lk_we    = 1'b1;
        lk_waddr = pos;
        lk_wdata = t;
      end
      OP_NONE, OP_LOAD, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Stores with registered reads; the link store read is write-first.
  always_ff @(posedge clk) begin
    if (lk_we_mem) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (vl_we) begin
      value_mem[t] <= x;
    end
    if (lk_re) begin
      lk_rdata <= (lk_we_mem && (lk_waddr == lk_raddr)) ? lk_wdata : link_mem[lk_raddr];
      vl_rdata <= value_mem[lk_raddr];
      rd_zero  <= (lk_raddr == '0);
    end
  end

  // Free-list top, sweep index and walk counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0;
      idx      <= '0;
      count    <= '0;
      first    <= 1'b1;
    end else begin
      if (lk_we && (lk_waddr == '0)) begin
        free_top <= lk_wdata;
      end else if (ft_set) begin
        free_top <= ft_val;
      end
      if (cmd.op == OP_SWEEP) begin
        idx <= sweep_last ? '0 : idx + node_t'(1);
      end
      case (cmd.op)
        OP_RD_HEAD: begin
          count <= '0;
          first <= 1'b1;
        end
        OP_CLEAR_HEAD: count <= '0;
        OP_ADVANCE: begin
          count <= count + CW'(1);
          first <= 1'b0;
        end
        OP_GIVE_ADV: count <= count + CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Operand and position registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x    <= x_in;
        head <= to_node(list_head);
        pos  <= to_node(position);
      end
      OP_RD_HEAD: cur <= head;
      OP_ADVANCE: begin
        prev <= cur;
        cur  <= rd_link;
      end
      OP_CLEAR_HEAD, OP_GIVE_ADV: cur <= rd_link;
      OP_TAKE_RD: t <= free_top;
      default: begin
      end
    endcase
  end

  // Result register, loaded when the controller emits a beat.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      case (cmd.res_sel)
        RES_T:    result_position <= to_field(t);
        RES_CUR:  result_position <= to_field(cur);
        RES_PREV: result_position <= to_field(prev);
        default:  result_position <= '0;
      endcase
      next_index  <= (cmd.res_sel == RES_READ) ? to_field(rd_link) : '0;
      element_out <= (cmd.res_sel == RES_READ) ? to_elem(vl_rdata) : '0;
      status      <= cmd.status;
    end
  end

  // Status back to the controller.
  assign stat.head_zero  = (head == '0);
  assign stat.free_empty = (free_top == '0);
  assign stat.match      = !first && (vl_rdata == x);
  assign stat.link_zero  = (rd_link == '0);
  assign stat.cur_zero   = (cur == '0);
  assign stat.count_full = (count == CW'(NODE_COUNT));
  assign stat.sweep_last = sweep_last;

  // A write to node 0 and a direct free-top update never collide.
  assert property (@(posedge clk) disable iff (rst)
    !(lk_we && (lk_waddr == '0) && ft_set))
    else $error("free-list top written twice in one cycle");

  // A walk never visits more nodes than the store holds.
  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(NODE_COUNT))
    else $error("walk counter ran past the node count");

  // A finished rebuild leaves node 1 on top of the free list.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SWEEP && sweep_last) |=> (free_top == node_t'(1)))
    else $error("free list not rebuilt from node 1");

endmodule

// ----- rtl/clle_ctrl.sv -----
// Controller of the linked-list engine: accepts command beats, sequences the
// datapath operations and owns the output valid flag.
// Depends on clle_pkg.
module clle_ctrl
  import clle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  output logic             out_valid,
  input  logic             out_ready,
  output dp_cmd_t          dp_cmd,
  input  dp_stat_t         dp_stat
);

  localparam logic [3:0] S_SWEEP    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HEAD     = 4'd2;
  localparam logic [3:0] S_SEARCH   = 4'd3;
  localparam logic [3:0] S_DEL_GIVE = 4'd4;
  localparam logic [3:0] S_FREE_CLR = 4'd5;
  localparam logic [3:0] S_FREE     = 4'd6;
  localparam logic [3:0] S_TAKE     = 4'd7;
  localparam logic [3:0] S_TAKE2    = 4'd8;
  localparam logic [3:0] S_INS_LINK = 4'd9;
  localparam logic [3:0] S_INS_HOOK = 4'd10;
  localparam logic [3:0] S_READ     = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [CMD_W-1:0]  cmd;
  logic [CMD_W-1:0]  cmd_next;
  res_sel_t          res_sel;
  res_sel_t          res_sel_next;
  logic [STAT_W-1:0] status;
  logic [STAT_W-1:0] status_next;
  logic              init_run;
  logic              init_run_next;
  logic              emit;

  assign in_ready = (state == S_IDLE);

  // Next-state and operation decode.
  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    res_sel_next   = res_sel;
    status_next    = status;
    init_run_next  = init_run;
    emit           = 1'b0;
    dp_cmd.op      = OP_NONE;
    dp_cmd.res_sel = res_sel;
    dp_cmd.status  = status;
    unique case (state)
      S_SWEEP: begin
        dp_cmd.op = OP_SWEEP;
        if (dp_stat.sweep_last) begin
          init_run_next = 1'b0;
          state_next    = init_run ? S_EMIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.op    = OP_LOAD;
          cmd_next     = in_command;
          res_sel_next = RES_NONE;
          status_next  = ST_OK;
          unique case (in_command) inside
            CMD_INIT: begin
              init_run_next = 1'b1;
              state_next    = S_SWEEP;
            end
            CMD_INSERT:    state_next = S_TAKE;
            CMD_READ_NODE: state_next = S_READ;
            CMD_MAKE_EMPTY, CMD_DELETE, CMD_FIND, CMD_FIND_PREV, CMD_DELETE_LIST:
              state_next = S_HEAD;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_HEAD: begin
        dp_cmd.op = OP_RD_HEAD;
        if (cmd == CMD_MAKE_EMPTY && dp_stat.head_zero) begin
          state_next = S_TAKE;
        end else if (cmd == CMD_MAKE_EMPTY || cmd == CMD_DELETE_LIST) begin
          state_next = S_FREE_CLR;
        end else begin
          state_next = S_SEARCH;
        end
      end
      // One node compared per cycle.
      S_SEARCH: begin
        if (dp_stat.match) begin
          if (cmd == CMD_FIND) begin
            res_sel_next = RES_CUR;
            state_next   = S_EMIT;
          end else if (cmd == CMD_FIND_PREV) begin
            res_sel_next = RES_PREV;
            state_next   = S_EMIT;
          end else begin
            dp_cmd.op  = OP_UNLINK;
            state_next = S_DEL_GIVE;
          end
        end else if (dp_stat.link_zero || dp_stat.count_full) begin
          if (cmd == CMD_DELETE) begin
            status_next = ST_NO_MATCH;
          end
          state_next = S_EMIT;
        end else begin
          dp_cmd.op = OP_ADVANCE;
        end
      end
      S_DEL_GIVE: begin
        dp_cmd.op  = OP_GIVE_CUR;
        state_next = S_EMIT;
      end
      S_FREE_CLR: begin
        dp_cmd.op  = OP_CLEAR_HEAD;
        state_next = S_FREE;
      end
      // One node returned to the free list per cycle.
      S_FREE: begin
        if (dp_stat.cur_zero || dp_stat.count_full) begin
          state_next = (cmd == CMD_MAKE_EMPTY) ? S_TAKE : S_EMIT;
        end else begin
          dp_cmd.op = OP_GIVE_ADV;
        end
      end
      S_TAKE: begin
        if (dp_stat.free_empty) begin
          status_next = ST_NO_SPACE;
          state_next  = S_EMIT;
        end else begin
          dp_cmd.op  = OP_TAKE_RD;
          state_next = S_TAKE2;
        end
      end
      S_TAKE2: begin
        if (cmd == CMD_INSERT) begin
          dp_cmd.op  = OP_TAKE_INS;
          state_next = S_INS_LINK;
        end else begin
          dp_cmd.op    = OP_TAKE_EMPTY;
          res_sel_next = RES_T;
          state_next   = S_EMIT;
        end
      end
      S_INS_LINK: begin
        dp_cmd.op  = OP_INS_LINK;
        state_next = S_INS_HOOK;
      end
      S_INS_HOOK: begin
        dp_cmd.op    = OP_INS_HOOK;
        res_sel_next = RES_T;
        state_next   = S_EMIT;
      end
      S_READ: begin
        dp_cmd.op    = OP_RD_POS;
        res_sel_next = RES_READ;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          dp_cmd.op  = OP_EMIT;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers; reset starts the link store rebuild.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      init_run  <= 1'b0;
      out_valid <= 1'b0;
      cmd       <= CMD_INIT;
      res_sel   <= RES_NONE;
      status    <= ST_OK;
    end else begin
      state    <= state_next;
      init_run <= init_run_next;
      cmd      <= cmd_next;
      res_sel  <= res_sel_next;
      status   <= status_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // An accepted beat always starts work.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != S_IDLE))
    else $error("accepted command left the controller idle");

  // A result appears only from the emit state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("output valid raised outside the emit state");

  // A finished result waits while the output register is still occupied.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && !out_ready) |=> (state == S_EMIT))
    else $error("result dropped while output stalled");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for the cursor linked-list engine: a directed command table, then random
// command sequences, each result checked against the table's expected beat or a behavioral model of the node store.
// Depends on clle_pkg and cursor_linked_list_engine.
module tb_top;
  import clle_pkg::*;

  localparam int NODES          = NODE_COUNT_DEF;
  localparam int HALF_PERIOD_NS = 2;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int DRAIN_CYCLES   = 2 * NODES;
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int RETRIES        = 16;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    elem_t            element;
    idx_t             list_head;
    idx_t             position;
  } cmd_beat_t;

  typedef struct packed {
    idx_t              result_position;
    idx_t              next_index;
    elem_t             element_out;
    logic [STAT_W-1:0] status;
  } result_beat_t;

  typedef struct packed {
    cmd_beat_t    beat;
    bit           typed;
    result_beat_t want;
  } dir_row_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // Model of the node store.
  idx_t  link_mem [NODES];
  elem_t elem_mem [NODES];
  bit    elem_set [NODES];

  // Expected result beats, oldest first.
  result_beat_t pending_results[$];
  result_beat_t want_beat;

  // Recently allocated headers, data nodes and stored values steer the random commands.
  idx_t  head_pool[$];
  idx_t  node_pool[$];
  elem_t value_pool[$];
  int    burst_left = 0;
  idx_t  burst_head = '0;

  int mismatches     = 0;
  int cycle_count    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int items_total    = 1;

  dir_row_t dir_table[$];

  cursor_linked_list_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HALF_PERIOD_NS clk = ~clk;

  // ---------------------------------------------------------------------------
  // Node store model
  // ---------------------------------------------------------------------------

  function automatic void rebuild_links();
    int i;
    for (i = 0; i < NODES; i++) link_mem[i] = idx_t'((i + 1) % NODES);
  endfunction

  function automatic idx_t take_free();
    idx_t p;
    p = link_mem[0];
    if (p != 0) link_mem[0] = link_mem[p];
    return p;
  endfunction

  function automatic void give_free(idx_t p);
    link_mem[p] = link_mem[0];
    link_mem[0] = p;
  endfunction

  // Frees every node after the header; a cyclic chain stops after NODES visits.
  function automatic void free_chain(idx_t head);
    idx_t p;
    idx_t nx;
    int   n;
    p = link_mem[head];
    link_mem[head] = '0;
    for (n = 0; n < NODES && p != 0; n++) begin
      nx = link_mem[p];
      give_free(p);
      p = nx;
    end
  endfunction

  // Returns {hit, node ahead of the first match}, starting at the header itself.
  function automatic logic [IDX_W:0] seek_pred(idx_t head, elem_t x);
    idx_t p;
    idx_t nx;
    int   n;
    p = head;
    for (n = 0; n < NODES; n++) begin
      nx = link_mem[p];
      if (nx == 0) return '0;
      if (elem_mem[nx] == x) return {1'b1, p};
      p = nx;
    end
    return '0;
  endfunction

  function automatic idx_t seek_value(idx_t head, elem_t x);
    idx_t p;
    int   n;
    p = link_mem[head];
    for (n = 0; n < NODES && p != 0; n++) begin
      if (elem_mem[p] == x) return p;
      p = link_mem[p];
    end
    return '0;
  endfunction

  // Applies one command to the model and returns the result beat it gives.
  function automatic result_beat_t run_list_command(cmd_beat_t b);
    result_beat_t r;
    idx_t         t;
    logic [IDX_W:0] hit;
    r = '0;
    r.status = ST_OK;
    case (b.command)
      CMD_INIT: rebuild_links();
      CMD_MAKE_EMPTY: begin
        if (b.list_head != 0) free_chain(b.list_head);
        t = take_free();
        if (t == 0) begin
          r.status = ST_NO_SPACE;
        end else begin
          link_mem[t] = '0;
          r.result_position = t;
        end
      end
      CMD_INSERT: begin
        t = take_free();
        if (t == 0) begin
          r.status = ST_NO_SPACE;
        end else begin
          elem_mem[t] = b.element;
          elem_set[t] = 1'b1;
          link_mem[t] = link_mem[b.position];
          link_mem[b.position] = t;
          r.result_position = t;
        end
      end
      CMD_DELETE: begin
        hit = seek_pred(b.list_head, b.element);
        if (hit[IDX_W]) begin
          t = link_mem[hit[IDX_W-1:0]];
          link_mem[hit[IDX_W-1:0]] = link_mem[t];
          give_free(t);
        end else begin
          r.status = ST_NO_MATCH;
        end
      end
      CMD_FIND: r.result_position = seek_value(b.list_head, b.element);
      CMD_FIND_PREV: begin
        hit = seek_pred(b.list_head, b.element);
        if (hit[IDX_W]) r.result_position = hit[IDX_W-1:0];
      end
      CMD_DELETE_LIST: free_chain(b.list_head);
      default: begin
        r.next_index  = link_mem[b.position];
        r.element_out = elem_mem[b.position];
      end
    endcase
    return r;
  endfunction

  // True when the command would compare or read an element that was never stored.
  function automatic bit reads_unset(cmd_beat_t b);
    idx_t p;
    idx_t nx;
    int   n;
    case (b.command)
      CMD_READ_NODE: return !elem_set[b.position];
      CMD_FIND: begin
        p = link_mem[b.list_head];
        for (n = 0; n < NODES && p != 0; n++) begin
          if (!elem_set[p]) return 1'b1;
          if (elem_mem[p] == b.element) return 1'b0;
          p = link_mem[p];
        end
      end
      CMD_DELETE, CMD_FIND_PREV: begin
        p = b.list_head;
        for (n = 0; n < NODES; n++) begin
          nx = link_mem[p];
          if (nx == 0) return 1'b0;
          if (!elem_set[nx]) return 1'b1;
          if (elem_mem[nx] == b.element) return 1'b0;
          p = nx;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Random command selection
  // ---------------------------------------------------------------------------

  function automatic elem_t pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4 && value_pool.size() != 0) return value_pool[$urandom_range(value_pool.size() - 1)];
    if (r == 4) return '0;
    if (r == 5) return '1;
    return $urandom;
  endfunction

  function automatic idx_t pick_head();
    if ($urandom_range(3) != 0 && head_pool.size() != 0)
      return head_pool[$urandom_range(head_pool.size() - 1)];
    return idx_t'($urandom);
  endfunction

  function automatic idx_t pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 45 && node_pool.size() != 0) return node_pool[$urandom_range(node_pool.size() - 1)];
    if (r < 75 && head_pool.size() != 0) return head_pool[$urandom_range(head_pool.size() - 1)];
    return idx_t'($urandom);
  endfunction

  // Mostly list-shaped traffic on known headers and nodes, with insert bursts
  // that drain the free list and a share of arbitrary indexes.
  function automatic cmd_beat_t pick_command();
    cmd_beat_t b;
    int        r;
    b.command   = CMD_READ_NODE;
    b.element   = pick_value();
    b.list_head = idx_t'($urandom);
    b.position  = pick_position();
    r = $urandom_range(999);
    if (burst_left == 0 && r < 6) begin
      burst_left = 48;
      burst_head = pick_head();
    end
    if (burst_left > 0) begin
      burst_left--;
      b.command = CMD_INSERT;
      if ($urandom_range(3) == 0 || node_pool.size() == 0) b.position = burst_head;
      else b.position = node_pool[$];
      return b;
    end
    if (r < 20) begin
      b.command = CMD_INIT;
    end else if (r < 100) begin
      b.command = CMD_MAKE_EMPTY;
      b.list_head = ($urandom_range(3) == 0) ? idx_t'(0) : pick_head();
    end else if (r < 380) begin
      b.command = CMD_INSERT;
    end else if (r < 530) begin
      b.command = CMD_DELETE;
      b.list_head = pick_head();
    end else if (r < 680) begin
      b.command = CMD_FIND;
      b.list_head = pick_head();
    end else if (r < 800) begin
      b.command = CMD_FIND_PREV;
      b.list_head = pick_head();
    end else if (r < 840) begin
      b.command = CMD_DELETE_LIST;
      b.list_head = ($urandom_range(6) == 0) ? idx_t'(0) : pick_head();
    end
    return b;
  endfunction

  // Keeps the pools in step with what the model says the command did.
  function automatic void note_result(cmd_beat_t b, result_beat_t r);
    case (b.command)
      CMD_INIT: begin
        head_pool.delete();
        node_pool.delete();
      end
      CMD_MAKE_EMPTY: begin
        if (r.status == ST_OK) head_pool.push_back(r.result_position);
        if (head_pool.size() > 8) void'(head_pool.pop_front());
      end
      CMD_INSERT: begin
        if (r.status == ST_OK) begin
          node_pool.push_back(r.result_position);
          value_pool.push_back(b.element);
        end else begin
          burst_left = 0;
        end
        if (node_pool.size() > 64) void'(node_pool.pop_front());
        if (value_pool.size() > 32) void'(value_pool.pop_front());
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Command channel driver
  // ---------------------------------------------------------------------------

  // Entered and left at a falling edge; the model runs at the accepting edge.
  task automatic send_command(input cmd_beat_t b, input bit typed, input result_beat_t want);
    result_beat_t         got;
    logic [S_TDATA_W-1:0] word;
    case ((items_sent * 4) / items_total)
      0: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_gap_pct   = 49;
        recv_stall_pct = 0;
      end
      2: begin
        send_gap_pct   = 0;
        recv_stall_pct = 49;
      end
      default: begin
        send_gap_pct   = 37;
        recv_stall_pct = 37;
      end
    endcase
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    word = '0;
    word[IN_ELEM_LO-1:0]        = b.command;
    word[IN_ELEM_LO +: ELEM_W]  = b.element;
    word[IN_HEAD_LO +: IDX_W]   = b.list_head;
    word[IN_POS_LO +: IDX_W]    = b.position;
    s_axis_tdata  = word;
    s_axis_tvalid = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    got = run_list_command(b);
    note_result(b, got);
    pending_results.push_back(typed ? want : got);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic dir_row_t row(logic [CMD_W-1:0] command, elem_t element, idx_t list_head,
                                   idx_t position, bit typed, idx_t rp, idx_t ni, elem_t eo,
                                   logic [STAT_W-1:0] st);
    dir_row_t d;
    d.beat.command   = command;
    d.beat.element   = element;
    d.beat.list_head = list_head;
    d.beat.position  = position;
    d.typed                = typed;
    d.want.result_position = rp;
    d.want.next_index      = ni;
    d.want.element_out     = eo;
    d.want.status          = st;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: ready pattern, checking and run limit
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, elem_t want, elem_t got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat 0x%0h with no command outstanding", m_axis_tdata);
        mismatches++;
      end else begin
        want_beat = pending_results.pop_front();
        check_field("result_position", elem_t'(want_beat.result_position),
                    elem_t'(m_axis_tdata[IDX_W-1:0]));
        check_field("next_index", elem_t'(want_beat.next_index),
                    elem_t'(m_axis_tdata[IDX_W +: IDX_W]));
        check_field("element_out", want_beat.element_out,
                    m_axis_tdata[2*IDX_W +: ELEM_W]);
        check_field("status", elem_t'(want_beat.status),
                    elem_t'(m_axis_tdata[2*IDX_W+ELEM_W +: STAT_W]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    cmd_beat_t b;
    int        k;
    int        tries;

    rebuild_links();

    // Directed commands from a fresh free list of nodes 1 through 255.
    // Insert after node 0 stores an element but leaves the free list as it was.
    dir_table.push_back(row(CMD_INSERT, 32'h0000_0000, 8'd0, 8'd0, 1, 8'd1, 8'd0, '0, ST_OK));
    dir_table.push_back(row(CMD_READ_NODE, 32'h0, 8'd0, 8'd1, 1, 8'd0, 8'd2, '0, ST_OK));
    dir_table.push_back(row(CMD_MAKE_EMPTY, 32'h0, 8'd0, 8'd0, 1, 8'd1, 8'd0, '0, ST_OK));
    dir_table.push_back(row(CMD_INSERT, 32'hFFFF_FFFF, 8'd0, 8'd1, 1, 8'd2, 8'd0, '0, ST_OK));
    dir_table.push_back(row(CMD_INSERT, 32'hA5A5_5A5A, 8'd0, 8'd2, 1, 8'd3, 8'd0, '0, ST_OK));
    dir_table.push_back(row(CMD_INSERT, 32'h0000_0001, 8'd0, 8'd1, 1, 8'd4, 8'd0, '0, ST_OK));
    dir_table.push_back(row(CMD_READ_NODE, 32'h0, 8'd0, 8'd4, 1, 8'd0, 8'd2, 32'h1, ST_OK));
    dir_table.push_back(row(CMD_FIND, 32'hFFFF_FFFF, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_FIND_PREV, 32'hA5A5_5A5A, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    // The predecessor of the first data node is the header itself.
    dir_table.push_back(row(CMD_FIND_PREV, 32'h0000_0001, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_FIND, 32'h5A5A_A5A5, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_FIND_PREV, 32'h5A5A_A5A5, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_DELETE, 32'h1234_5678, 8'd1, 8'd0, 1, '0, '0, '0, ST_NO_MATCH));
    dir_table.push_back(row(CMD_DELETE, 32'hFFFF_FFFF, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    // Inserting after the tail of the free list bends it into a longer chain.
    dir_table.push_back(row(CMD_INSERT, 32'h8000_0000, 8'd0, 8'd255, 0, '0, '0, '0, ST_OK));
    // Make empty on a live header frees its nodes before taking a new header.
    dir_table.push_back(row(CMD_MAKE_EMPTY, 32'h0, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    // Freeing after node 0 walks the free list and gives every node back.
    dir_table.push_back(row(CMD_DELETE_LIST, 32'h0, 8'd0, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_INSERT, 32'h7FFF_FFFF, 8'd255, 8'd3, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_DELETE_LIST, 32'h0, 8'd3, 8'd0, 0, '0, '0, '0, ST_OK));
    // After a rebuild, inserting node 1 after itself leaves a node that links to itself.
    dir_table.push_back(row(CMD_INIT, 32'h0, 8'd0, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_INSERT, 32'h3C3C_3C3C, 8'd0, 8'd1, 1, 8'd1, 8'd0, '0, ST_OK));
    // A search around the loop gives up after a full store of visits.
    dir_table.push_back(row(CMD_FIND, 32'hDEAD_BEEF, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_DELETE_LIST, 32'h0, 8'd1, 8'd0, 0, '0, '0, '0, ST_OK));
    dir_table.push_back(row(CMD_READ_NODE, 32'h0, 8'd0, 8'd3, 0, '0, '0, '0, ST_OK));
    items_total = dir_table.size() + RANDOM_ITEMS;

    // Reset, then start driving from a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_table[i]) send_command(dir_table[i].beat, dir_table[i].typed,
                                        dir_table[i].want);

    // Random part. It opens with a rebuild, one header and inserts until the store runs out.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 0) begin
        b = '0;
        b.command = CMD_INIT;
      end else if (k == 1) begin
        b = '0;
        b.command = CMD_MAKE_EMPTY;
      end else begin
        b = pick_command();
        tries = 0;
        while (reads_unset(b) && tries < RETRIES) begin
          b = pick_command();
          tries++;
        end
        if (reads_unset(b)) b.command = CMD_INSERT;
      end
      send_command(b, 1'b0, '0);
      if (k == 1) begin
        burst_head = head_pool[$];
        burst_left = NODES;
      end
    end
    s_axis_tvalid = 1'b0;

    // Wait for every result, then watch a while longer for stray beats.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
